FILE: hw/rtl/xylmi_pkg.sv
// xylmi_pkg: shared types and constants of the xy linear move interpolator
// no dependencies; used by the arithmetic unit, the top level and the testbench
`timescale 1ns / 1ps
`default_nettype none

package xylmi_pkg;

  localparam int unsigned ACC_W = 128;
  localparam int unsigned OPD_W = 64;
  localparam int unsigned LEN_W = 8;

  localparam logic [2:0] OP_MOVE_ABS = 3'd0;
  localparam logic [2:0] OP_MOVE_REL = 3'd1;
  localparam logic [2:0] OP_QUERY    = 3'd2;
  localparam logic [2:0] OP_STOP     = 3'd3;
  localparam logic [2:0] OP_TICK     = 3'd4;

  localparam logic CFG_STEP_SIZE = 1'b0;
  localparam logic CFG_VELOCITY  = 1'b1;

  localparam logic [31:0] STEP_RESET = 32'd65536;
  localparam logic [31:0] VEL_RESET  = 32'd655360;
  localparam logic [31:0] VEL_MIN    = 32'd6554;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_t;

  typedef struct packed {
    logic             start;
    alu_op_t          op;
    logic [LEN_W-1:0] len;
  } alu_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_IMUL,
    S_IDIV,
    S_POST,
    S_TARGET,
    S_SQX,
    S_SQY,
    S_SQRT,
    S_DMUL,
    S_DDIV,
    S_OUT
  } seq_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/xylmi_in_if.sv
// xylmi_in_if: request channel of the interpolator, valid/ready with op and offsets
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface xylmi_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [31:0] x_steps;
  logic [31:0] y_steps;

  modport source (output valid, output op, output x_steps, output y_steps, input ready);
  modport sink (input valid, input op, input x_steps, input y_steps, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/xylmi_out_if.sv
// xylmi_out_if: result channel of the interpolator, valid/ready with position and busy
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface xylmi_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic        busy_res;

  modport source (output valid, output pos_x, output pos_y, output busy_res, input ready);
  modport sink (input valid, input pos_x, input pos_y, input busy_res, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/xy_linear_move_interpolator.sv
// xy_linear_move_interpolator: two-axis stage move model, one request at a time
// while a move runs, a request other than a final tick first interpolates both axes by multiply and divide
// a move request adds squares, root, multiply and divide in the shared unit
// a new request is taken only back in idle, after the last result is registered; a waiting result holds it off
// reset: synchronous active low; position zero, idle, step size 1.0, velocity 10.0
// depends on xylmi_pkg, xylmi_in_if, xylmi_out_if, xylmi_alu
`timescale 1ns / 1ps
`default_nettype none

module xy_linear_move_interpolator #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned POS_BITS  = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  xylmi_in_if.sink         in_ch,
  xylmi_out_if.source      out_ch,
  input  wire logic        cfg_we,
  input  wire logic        cfg_idx,
  input  wire logic [31:0] cfg_data
);

  localparam int unsigned PW      = POS_BITS + FRAC_BITS;
  localparam int unsigned IDIV_SH = xylmi_pkg::ACC_W - (PW + 32);
  localparam bit          HALVE   = (PW == 64);

  function automatic logic [PW-1:0] diff_mag(input logic [PW-1:0] s, input logic [PW-1:0] t);
    if ($signed(t) >= $signed(s)) return t - s;
    return s - t;
  endfunction

  function automatic logic [POS_BITS-1:0] trunc_steps(input logic [PW-1:0] p);
    logic [PW-1:0] bias;
    bias = p + (p[PW-1] ? PW'({FRAC_BITS{1'b1}}) : PW'(0));
    return bias[PW-1:FRAC_BITS];
  endfunction

  xylmi_pkg::seq_state_t state_r, state_nxt;
  logic                  issued_r, issued_nxt;
  logic                  axis_r, axis_nxt;
  logic                  moving_r, moving_nxt;
  logic [31:0]           elapsed_r, elapsed_nxt;
  logic [31:0]           duration_r, duration_nxt;
  logic [31:0]           step_r, vel_r;
  logic [PW-1:0]         settled_x_r, settled_x_nxt, settled_y_r, settled_y_nxt;
  logic [PW-1:0]         start_x_r, start_x_nxt, start_y_r, start_y_nxt;
  logic [PW-1:0]         target_x_r, target_x_nxt, target_y_r, target_y_nxt;
  logic [PW-1:0]         cx_r, cx_nxt, cy_r, cy_nxt;
  logic [2:0]            op_r, op_nxt;
  logic [31:0]           xin_r, xin_nxt, yin_r, yin_nxt;
  logic [127:0]          sq_r, sq_nxt;
  logic [63:0]           root_r, root_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [31:0]           out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic                  out_busy_r, out_busy_nxt;

  xylmi_pkg::alu_req_t   alu_req;
  logic [127:0]          alu_a;
  logic [63:0]           alu_b;
  logic                  alu_done;
  logic [127:0]          alu_res;

  logic [PW-1:0]         is_s, is_t, is_mag, is_pos, is_delta;
  logic                  is_neg;
  logic [PW-1:0]         mag_x, mag_y, sq_in;
  logic                  halved;
  logic [63:0]           root_q;
  logic [31:0]           el_inc;
  logic [POS_BITS-1:0]   tx_steps, ty_steps;
  logic                  is_move;

  xylmi_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .a     (alu_a),
    .b     (alu_b),
    .done  (alu_done),
    .res   (alu_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= xylmi_pkg::S_IDLE;
      issued_r    <= 1'b0;
      moving_r    <= 1'b0;
      elapsed_r   <= '0;
      duration_r  <= 32'd1;
      settled_x_r <= '0;
      settled_y_r <= '0;
      start_x_r   <= '0;
      start_y_r   <= '0;
      target_x_r  <= '0;
      target_y_r  <= '0;
      out_valid_r <= 1'b0;
      step_r      <= xylmi_pkg::STEP_RESET;
      vel_r       <= xylmi_pkg::VEL_RESET;
    end else begin
      state_r     <= state_nxt;
      issued_r    <= issued_nxt;
      moving_r    <= moving_nxt;
      elapsed_r   <= elapsed_nxt;
      duration_r  <= duration_nxt;
      settled_x_r <= settled_x_nxt;
      settled_y_r <= settled_y_nxt;
      start_x_r   <= start_x_nxt;
      start_y_r   <= start_y_nxt;
      target_x_r  <= target_x_nxt;
      target_y_r  <= target_y_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          xylmi_pkg::CFG_STEP_SIZE: step_r <= cfg_data;
          default: vel_r <= (cfg_data < xylmi_pkg::VEL_MIN) ? xylmi_pkg::VEL_MIN : cfg_data;
        endcase
      end
    end
    axis_r     <= axis_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    op_r       <= op_nxt;
    xin_r      <= xin_nxt;
    yin_r      <= yin_nxt;
    sq_r       <= sq_nxt;
    root_r     <= root_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_busy_r <= out_busy_nxt;
  end

  // per-axis interpolation operands
  always_comb begin
    is_s     = axis_r ? start_y_r : start_x_r;
    is_t     = axis_r ? target_y_r : target_x_r;
    is_mag   = diff_mag(is_s, is_t);
    is_neg   = $signed(is_t) < $signed(is_s);
    is_delta = alu_res[PW-1:0];
    is_pos   = is_neg ? is_s - is_delta : is_s + is_delta;
    mag_x    = diff_mag(start_x_r, target_x_r);
    mag_y    = diff_mag(start_y_r, target_y_r);
    halved   = HALVE && (mag_x[PW-1] | mag_y[PW-1]);
    sq_in    = (state_r == xylmi_pkg::S_SQY) ? mag_y : mag_x;
    if (halved) sq_in = sq_in >> 1;
    root_q   = alu_res[63:0];
    el_inc   = elapsed_r + 32'd1;
    tx_steps = POS_BITS'($signed(xin_r));
    ty_steps = POS_BITS'($signed(yin_r));
    if (op_r == xylmi_pkg::OP_MOVE_REL) begin
      tx_steps = trunc_steps(cx_r) + tx_steps;
      ty_steps = trunc_steps(cy_r) + ty_steps;
    end
    is_move  = (op_r == xylmi_pkg::OP_MOVE_ABS) || (op_r == xylmi_pkg::OP_MOVE_REL);
  end

  always_comb begin
    state_nxt     = state_r;
    issued_nxt    = issued_r;
    axis_nxt      = axis_r;
    moving_nxt    = moving_r;
    elapsed_nxt   = elapsed_r;
    duration_nxt  = duration_r;
    settled_x_nxt = settled_x_r;
    settled_y_nxt = settled_y_r;
    start_x_nxt   = start_x_r;
    start_y_nxt   = start_y_r;
    target_x_nxt  = target_x_r;
    target_y_nxt  = target_y_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    op_nxt        = op_r;
    xin_nxt       = xin_r;
    yin_nxt       = yin_r;
    sq_nxt        = sq_r;
    root_nxt      = root_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_busy_nxt  = out_busy_r;
    alu_req.start = 1'b0;
    alu_req.op    = xylmi_pkg::ALU_MUL;
    alu_req.len   = xylmi_pkg::LEN_W'(64);
    alu_a         = '0;
    alu_b         = '0;

    case (state_r)
      xylmi_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt    = in_ch.op;
          xin_nxt   = in_ch.x_steps;
          yin_nxt   = in_ch.y_steps;
          state_nxt = xylmi_pkg::S_DECODE;
        end
      end
      xylmi_pkg::S_DECODE: begin
        axis_nxt = 1'b0;
        cx_nxt   = settled_x_r;
        cy_nxt   = settled_y_r;
        if (!moving_r) begin
          state_nxt = is_move ? xylmi_pkg::S_TARGET : xylmi_pkg::S_OUT;
        end else if (op_r == xylmi_pkg::OP_TICK) begin
          elapsed_nxt = el_inc;
          if (el_inc >= duration_r) begin
            settled_x_nxt = target_x_r;
            settled_y_nxt = target_y_r;
            cx_nxt        = target_x_r;
            cy_nxt        = target_y_r;
            moving_nxt    = 1'b0;
            state_nxt     = xylmi_pkg::S_OUT;
          end else begin
            state_nxt = xylmi_pkg::S_IMUL;
          end
        end else begin
          state_nxt = xylmi_pkg::S_IMUL;
        end
      end
      xylmi_pkg::S_IMUL: begin
        alu_a = 128'(is_mag);
        alu_b = 64'(elapsed_r);
        if (!issued_r) begin
          alu_req.start = 1'b1;
          issued_nxt    = 1'b1;
        end else if (alu_done) begin
          sq_nxt     = alu_res;
          issued_nxt = 1'b0;
          state_nxt  = xylmi_pkg::S_IDIV;
        end
      end
      xylmi_pkg::S_IDIV: begin
        alu_req.op  = xylmi_pkg::ALU_DIV;
        alu_req.len = xylmi_pkg::LEN_W'(PW + 32);
        alu_a       = sq_r << IDIV_SH;
        alu_b       = 64'(duration_r);
        if (!issued_r) begin
          alu_req.start = 1'b1;
          issued_nxt    = 1'b1;
        end else if (alu_done) begin
          issued_nxt = 1'b0;
          if (!axis_r) begin
            cx_nxt    = is_pos;
            axis_nxt  = 1'b1;
            state_nxt = xylmi_pkg::S_IMUL;
          end else begin
            cy_nxt    = is_pos;
            state_nxt = xylmi_pkg::S_POST;
          end
        end
      end
      xylmi_pkg::S_POST: begin
        if (is_move) begin
          state_nxt = xylmi_pkg::S_TARGET;
        end else begin
          if (op_r == xylmi_pkg::OP_STOP) begin
            settled_x_nxt = cx_r;
            settled_y_nxt = cy_r;
            moving_nxt    = 1'b0;
          end
          state_nxt = xylmi_pkg::S_OUT;
        end
      end
      xylmi_pkg::S_TARGET: begin
        start_x_nxt   = cx_r;
        start_y_nxt   = cy_r;
        settled_x_nxt = cx_r;
        settled_y_nxt = cy_r;
        target_x_nxt  = {tx_steps, {FRAC_BITS{1'b0}}};
        target_y_nxt  = {ty_steps, {FRAC_BITS{1'b0}}};
        elapsed_nxt   = '0;
        moving_nxt    = 1'b1;
        state_nxt     = xylmi_pkg::S_SQX;
      end
      xylmi_pkg::S_SQX, xylmi_pkg::S_SQY: begin
        alu_a = 128'(sq_in);
        alu_b = 64'(sq_in);
        if (!issued_r) begin
          alu_req.start = 1'b1;
          issued_nxt    = 1'b1;
        end else if (alu_done) begin
          issued_nxt = 1'b0;
          if (state_r == xylmi_pkg::S_SQX) begin
            sq_nxt    = alu_res;
            state_nxt = xylmi_pkg::S_SQY;
          end else begin
            sq_nxt    = sq_r + alu_res;
            state_nxt = xylmi_pkg::S_SQRT;
          end
        end
      end
      xylmi_pkg::S_SQRT: begin
        alu_req.op = xylmi_pkg::ALU_SQRT;
        alu_a      = sq_r;
        if (!issued_r) begin
          alu_req.start = 1'b1;
          issued_nxt    = 1'b1;
        end else if (alu_done) begin
          issued_nxt = 1'b0;
          if (halved) root_nxt = root_q[63] ? '1 : {root_q[62:0], 1'b0};
          else root_nxt = root_q;
          state_nxt = xylmi_pkg::S_DMUL;
        end
      end
      xylmi_pkg::S_DMUL: begin
        alu_a = 128'(root_r);
        alu_b = 64'(step_r);
        if (!issued_r) begin
          alu_req.start = 1'b1;
          issued_nxt    = 1'b1;
        end else if (alu_done) begin
          sq_nxt     = alu_res;
          issued_nxt = 1'b0;
          state_nxt  = xylmi_pkg::S_DDIV;
        end
      end
      xylmi_pkg::S_DDIV: begin
        alu_req.op  = xylmi_pkg::ALU_DIV;
        alu_req.len = xylmi_pkg::LEN_W'(96);
        alu_a       = sq_r << 32;
        alu_b       = 64'({vel_r, {FRAC_BITS{1'b0}}});
        if (!issued_r) begin
          alu_req.start = 1'b1;
          issued_nxt    = 1'b1;
        end else if (alu_done) begin
          issued_nxt = 1'b0;
          if (|alu_res[95:32]) duration_nxt = '1;
          else if (alu_res[31:0] == 32'd0) duration_nxt = 32'd1;
          else duration_nxt = alu_res[31:0];
          state_nxt = xylmi_pkg::S_OUT;
        end
      end
      xylmi_pkg::S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_x_nxt     = 32'($signed(trunc_steps(cx_r)));
          out_y_nxt     = 32'($signed(trunc_steps(cy_r)));
          out_busy_nxt  = moving_r;
          state_nxt     = xylmi_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = xylmi_pkg::S_IDLE;
      end
    endcase
  end

  assign in_ch.ready     = (state_r == xylmi_pkg::S_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.pos_x    = out_x_r;
  assign out_ch.pos_y    = out_y_r;
  assign out_ch.busy_res = out_busy_r;

endmodule

`default_nettype wire

FILE: hw/rtl/xylmi_alu.sv
// xylmi_alu: shared bit-serial unit, shift-add multiply, restoring divide and square root
// depends on xylmi_pkg
`timescale 1ns / 1ps
`default_nettype none

module xylmi_alu (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire xylmi_pkg::alu_req_t            req,
  input  wire logic [xylmi_pkg::ACC_W-1:0]    a,
  input  wire logic [xylmi_pkg::OPD_W-1:0]    b,
  output logic                                done,
  output logic [xylmi_pkg::ACC_W-1:0]         res
);

  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  xylmi_pkg::alu_op_t            op_r, op_nxt;
  logic [xylmi_pkg::LEN_W-1:0]   cnt_r, cnt_nxt;
  logic [xylmi_pkg::ACC_W-1:0]   x_r, x_nxt;
  logic [66:0]                   r_r, r_nxt;
  logic [63:0]                   q_r, q_nxt;
  logic [63:0]                   d_r, d_nxt;

  logic [64:0] mul_sum;
  logic [64:0] div_r2;
  logic [66:0] sq_rr;
  logic [66:0] sq_trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r  <= op_nxt;
    cnt_r <= cnt_nxt;
    x_r   <= x_nxt;
    r_r   <= r_nxt;
    q_r   <= q_nxt;
    d_r   <= d_nxt;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    op_nxt   = op_r;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    r_nxt    = r_r;
    q_nxt    = q_r;
    d_nxt    = d_r;
    mul_sum  = {1'b0, x_r[127:64]} + (x_r[0] ? {1'b0, d_r} : 65'd0);
    div_r2   = {r_r[63:0], x_r[127]};
    sq_rr    = {r_r[64:0], x_r[127:126]};
    sq_trial = {1'b0, q_r, 2'b01};
    if (req.start) begin
      busy_nxt = 1'b1;
      op_nxt   = req.op;
      cnt_nxt  = req.len;
      r_nxt    = '0;
      q_nxt    = '0;
      case (req.op)
        xylmi_pkg::ALU_MUL: begin
          x_nxt = {64'd0, b};
          d_nxt = a[63:0];
        end
        default: begin
          x_nxt = a;
          d_nxt = b;
        end
      endcase
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == xylmi_pkg::LEN_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
      case (op_r)
        xylmi_pkg::ALU_MUL: begin
          x_nxt = {mul_sum, x_r[63:1]};
        end
        xylmi_pkg::ALU_DIV: begin
          if (div_r2 >= {1'b0, d_r}) begin
            r_nxt = 67'(div_r2 - {1'b0, d_r});
            x_nxt = {x_r[126:0], 1'b1};
          end else begin
            r_nxt = 67'(div_r2);
            x_nxt = {x_r[126:0], 1'b0};
          end
        end
        default: begin
          x_nxt = {x_r[125:0], 2'b00};
          if (sq_rr >= sq_trial) begin
            r_nxt = sq_rr - sq_trial;
            q_nxt = {q_r[62:0], 1'b1};
          end else begin
            r_nxt = sq_rr;
            q_nxt = {q_r[62:0], 1'b0};
          end
        end
      endcase
    end
  end

  assign done = done_r;
  assign res  = (op_r == xylmi_pkg::ALU_SQRT) ? {64'd0, q_r} : x_r;

endmodule

`default_nettype wire

FILE: bench/xy_linear_move_interpolator_tb.sv
// xy_linear_move_interpolator_tb: self-checking bench for the two-axis move interpolator
// predicts position and busy per request in a scoreboard class and checks every result
// depends on xylmi_pkg, xylmi_in_if, xylmi_out_if and the xy_linear_move_interpolator rtl
`timescale 1ns / 1ps

module xy_linear_move_interpolator_tb;

  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_TOP = 3'd7;
  localparam int SETTLE_CYCLES = 800;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 3000;

  typedef logic [47:0] fix_t;

  typedef struct packed {
    logic [31:0] px;
    logic [31:0] py;
    logic        busy;
  } pos_t;

  class move_scoreboard;
    fix_t settled_x, settled_y, start_x, start_y, target_x, target_y;
    logic [31:0] elapsed, dur;
    bit moving;
    logic [31:0] step_size, velocity;
    pos_t expected_q[$];
    int fails;

    function new();
      settled_x = '0; settled_y = '0; start_x = '0; start_y = '0;
      target_x = '0; target_y = '0;
      elapsed = '0; dur = 32'd1; moving = 0;
      step_size = xylmi_pkg::STEP_RESET; velocity = xylmi_pkg::VEL_RESET;
      fails = 0;
    endfunction

    function void set_reg(logic idx, logic [31:0] val);
      if (idx == xylmi_pkg::CFG_STEP_SIZE) step_size = val;
      else velocity = (val < xylmi_pkg::VEL_MIN) ? xylmi_pkg::VEL_MIN : val;
    endfunction

    function logic [48:0] span(fix_t s, fix_t t, output bit neg);
      longint ss, ts;
      ss = longint'($signed(s));
      ts = longint'($signed(t));
      neg = ts < ss;
      return neg ? 49'(ss - ts) : 49'(ts - ss);
    endfunction

    function fix_t lerp(fix_t s, fix_t t);
      bit neg;
      logic [127:0] prod;
      logic [31:0] d, e;
      prod = 128'(span(s, t, neg));
      d = (dur == 0) ? 32'd1 : dur;
      e = (elapsed < d) ? elapsed : d;
      prod = (prod * 128'(e)) / 128'(d);
      return neg ? s - prod[47:0] : s + prod[47:0];
    endfunction

    function fix_t cur_x();
      return moving ? lerp(start_x, target_x) : settled_x;
    endfunction

    function fix_t cur_y();
      return moving ? lerp(start_y, target_y) : settled_y;
    endfunction

    function logic [31:0] whole_steps(fix_t p);
      longint v;
      logic [63:0] u;
      v = longint'($signed(p));
      if (v < 0) begin
        u = -v;
        u = 64'd0 - (u >> 16);
      end else begin
        u = v;
        u = u >> 16;
      end
      return u[31:0];
    endfunction

    function logic [63:0] root(logic [127:0] n);
      logic [63:0] r;
      logic [127:0] c;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
        c = 128'(r | (64'd1 << b));
        if (c * c <= n) r = c[63:0];
      end
      return r;
    endfunction

    function logic [31:0] travel_ms();
      bit neg;
      logic [127:0] mx, my, num, den;
      mx = 128'(span(start_x, target_x, neg));
      my = 128'(span(start_y, target_y, neg));
      num = 128'(root(mx * mx + my * my));
      num = num * 128'(step_size);
      den = 128'(velocity);
      den = den << 16;
      num = num / den;
      if (num > 128'hFFFF_FFFF) return 32'hFFFF_FFFF;
      if (num == 0) return 32'd1;
      return num[31:0];
    endfunction

    function void note(logic [2:0] op, logic [31:0] xs, logic [31:0] ys);
      fix_t cx, cy, px, py;
      logic [31:0] tx, ty;
      case (op)
        xylmi_pkg::OP_MOVE_ABS, xylmi_pkg::OP_MOVE_REL: begin
          cx = cur_x();
          cy = cur_y();
          tx = (op == xylmi_pkg::OP_MOVE_ABS) ? xs : whole_steps(cx) + xs;
          ty = (op == xylmi_pkg::OP_MOVE_ABS) ? ys : whole_steps(cy) + ys;
          start_x = cx; settled_x = cx;
          start_y = cy; settled_y = cy;
          target_x = {tx, 16'd0};
          target_y = {ty, 16'd0};
          elapsed = '0;
          dur = travel_ms();
          moving = 1;
          px = cx; py = cy;
        end
        xylmi_pkg::OP_STOP: begin
          if (moving) begin
            settled_x = cur_x();
            settled_y = cur_y();
            moving = 0;
          end
          px = settled_x; py = settled_y;
        end
        default: begin
          if (op == xylmi_pkg::OP_TICK && moving) begin
            elapsed++;
            if (elapsed >= dur) begin
              settled_x = target_x;
              settled_y = target_y;
              moving = 0;
            end
          end
          px = cur_x(); py = cur_y();
        end
      endcase
      expected_q.push_back('{whole_steps(px), whole_steps(py), moving});
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      fails++;
      $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
    endtask

    task check(logic [31:0] px, logic [31:0] py, logic busy);
      pos_t e;
      if (expected_q.size() == 0) begin
        report("unexpected result", {px[15:0], py[15:0]}, 32'd0);
      end else begin
        e = expected_q.pop_front();
        if (px !== e.px) report("pos_x", px, e.px);
        if (py !== e.py) report("pos_y", py, e.py);
        if (busy !== e.busy) report("busy_res", 32'(busy), 32'(e.busy));
      end
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_idx;
  logic [31:0] cfg_data;
  bit no_idle = 0;
  bit hold_req = 0;
  int quiet_cycles = 0;
  move_scoreboard sb = new();

  xylmi_in_if in_ch();
  xylmi_out_if out_ch();

  xy_linear_move_interpolator dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(20, 60);
  endfunction

  function logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      default: return 32'($urandom_range(0, 200)) - 32'd100;
    endcase
  endfunction

  // requests and results are observed on the falling edge, where nothing is changing
  always @(negedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) sb.note(in_ch.op, in_ch.x_steps, in_ch.y_steps);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check(out_ch.pos_x, out_ch.pos_y, out_ch.busy_res);
  end

  always @(posedge clk) begin
    if (rst_n && ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
      end
      stall = pick_gap();
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  task send_req(logic [2:0] op, logic [31:0] xs, logic [31:0] ys);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.x_steps <= xs;
    in_ch.y_steps <= ys;
    forever begin
      @(negedge clk);
      if (in_ch.ready) break;
    end
    @(posedge clk);
  endtask

  task drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_reg(logic idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task random_moves(int n);
    int sent, ticks;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 3) != 0) begin
        send_req($urandom_range(0, 1) ? xylmi_pkg::OP_MOVE_ABS : xylmi_pkg::OP_MOVE_REL,
                 pick_coord(), pick_coord());
        sent++;
        ticks = $urandom_range(0, 20);
        repeat (ticks) begin
          case ($urandom_range(0, 9))
            0: send_req(xylmi_pkg::OP_QUERY, $urandom, $urandom);
            1: send_req(xylmi_pkg::OP_STOP, $urandom, $urandom);
            default: send_req(xylmi_pkg::OP_TICK, $urandom, $urandom);
          endcase
          sent++;
        end
      end else begin
        send_req(3'($urandom_range(0, OP_TOP)), $urandom, $urandom);
        sent++;
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= xylmi_pkg::CFG_STEP_SIZE;
    cfg_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.op <= xylmi_pkg::OP_QUERY;
    in_ch.x_steps <= '0;
    in_ch.y_steps <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, every op, stop idle and moving, wrap, spare codes
    send_req(xylmi_pkg::OP_MOVE_ABS, 32'd100, -32'sd50);
    send_req(xylmi_pkg::OP_QUERY, '0, '0);
    repeat (3) send_req(xylmi_pkg::OP_TICK, '0, '0);
    send_req(xylmi_pkg::OP_STOP, '0, '0);
    send_req(xylmi_pkg::OP_STOP, '0, '0);
    send_req(xylmi_pkg::OP_MOVE_REL, -32'sd3, 32'd7);
    repeat (3) send_req(xylmi_pkg::OP_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(xylmi_pkg::OP_MOVE_ABS, 32'h7FFF_FFFF, 32'h8000_0000);
    send_req(xylmi_pkg::OP_TICK, '0, '0);
    send_req(xylmi_pkg::OP_STOP, '0, '0);
    send_req(xylmi_pkg::OP_MOVE_REL, 32'h7FFF_FFFF, 32'h8000_0000);
    send_req(xylmi_pkg::OP_STOP, '0, '0);
    send_req(xylmi_pkg::OP_MOVE_ABS, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(OP_SPARE_A, '0, '0);
    send_req(OP_SPARE_B, '0, '0);
    send_req(OP_TOP, '0, '0);
    send_req(xylmi_pkg::OP_MOVE_REL, '0, '0);
    send_req(xylmi_pkg::OP_TICK, '0, '0);
    send_req(xylmi_pkg::OP_MOVE_ABS, '0, '0);
    send_req(xylmi_pkg::OP_TICK, '0, '0);
    drain();

    random_moves(300);
    drain();

    // one millisecond moves, with a long receiver hold-off
    write_reg(xylmi_pkg::CFG_STEP_SIZE, 32'd1);
    write_reg(xylmi_pkg::CFG_VELOCITY, 32'hFFFF_FFFF);
    hold_req = 1;
    random_moves(300);
    drain();

    // clamped velocity, very long moves
    write_reg(xylmi_pkg::CFG_STEP_SIZE, 32'hFFFF_FFFF);
    write_reg(xylmi_pkg::CFG_VELOCITY, 32'd0);
    no_idle = 1;
    random_moves(100);
    no_idle = 0;
    random_moves(150);
    drain();

    write_reg(xylmi_pkg::CFG_STEP_SIZE, 32'd0);
    write_reg(xylmi_pkg::CFG_VELOCITY, 32'd6553);
    random_moves(60);
    drain();

    write_reg(xylmi_pkg::CFG_STEP_SIZE, 32'd40000);
    write_reg(xylmi_pkg::CFG_VELOCITY, 32'd100000);
    random_moves(320);
    drain();

    if (sb.fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
